[rtl/aarm_pkg.sv]
package aarm_pkg;

  typedef struct packed {
    logic signed [31:0] angle;
    logic               angle_in_degrees;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic signed [31:0] elem_3;
    logic signed [31:0] elem_4;
    logic signed [31:0] elem_5;
    logic signed [31:0] elem_6;
    logic signed [31:0] elem_7;
    logic signed [31:0] elem_8;
    logic               axis_zero;
  } out_t;

  // angle scale to turns, Q0.48 per input lsb
  localparam logic [47:0] RadTurns = 48'h28BE_60DB_9391;
  localparam logic [47:0] DegTurns = 48'h00B6_0B60_B60B;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam int AtanEntries = 30;

  // axis path depth: magnitude, shift search, shift, square, sum,
  // root steps, numerator, quotient steps, sign
  localparam int SqrtSteps   = 32;
  localparam int DivSteps    = 31;
  localparam int AxisLatency = 6 + SqrtSteps + DivSteps + 1;

  function automatic int cordic_count(input int stages);
    return (stages > AtanEntries) ? AtanEntries : stages;
  endfunction

  // arctangent of 2^-i in turns, Q0.32
  function automatic logic [29:0] atan_turns(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // clamp to [-1.0, 1.0] in Q2.30
  function automatic logic signed [31:0] sat_q30(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -36'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/aarm_sincos.sv]
module aarm_sincos #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] angle,
  input  logic               deg,
  output logic               out_valid,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  localparam int NumStages = aarm_pkg::cordic_count(CORDIC_STAGES);

  logic        [22:0] turns_lo;
  logic        [22:0] turns_hi;
  logic signed [55:0] prod_lo;
  logic signed [55:0] prod_hi;
  logic               prod_valid;
  logic        [63:0] phase_full;
  logic        [63:0] phase_rnd;
  logic        [31:0] turn_shift;

  logic signed [33:0] x [0:NumStages];
  logic signed [33:0] y [0:NumStages];
  logic signed [33:0] z [0:NumStages];
  logic        [1:0]  quad [0:NumStages];
  logic               stage_valid [0:NumStages];

  logic signed [33:0] c_pre;
  logic signed [33:0] s_pre;

  // angle times turn scale, split in two partial products
  assign turns_lo = deg ? aarm_pkg::DegTurns[22:0]  : aarm_pkg::RadTurns[22:0];
  assign turns_hi = deg ? aarm_pkg::DegTurns[45:23] : aarm_pkg::RadTurns[45:23];

  always_ff @(posedge clk) begin
    prod_lo <= angle * $signed({1'b0, turns_lo});
    prod_hi <= angle * $signed({1'b0, turns_hi});
  end

  assign phase_full = ({{8{prod_hi[55]}}, prod_hi} << 23) + {{8{prod_lo[55]}}, prod_lo};
  assign phase_rnd  = phase_full + 64'h0000_0000_8000_0000;
  assign turn_shift = phase_rnd[63:32] + 32'h2000_0000;

  always_ff @(posedge clk) begin
    x[0]    <= aarm_pkg::CordicGain;
    y[0]    <= '0;
    z[0]    <= $signed({4'b0000, turn_shift[29:0]}) - 34'sd536870912;
    quad[0] <= turn_shift[31:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid     <= 1'b0;
      stage_valid[0] <= 1'b0;
    end else begin
      prod_valid     <= in_valid;
      stage_valid[0] <= prod_valid;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < NumStages; i++) begin : g_rot
    logic signed [33:0] atan_c;
    assign atan_c = $signed({4'b0000, aarm_pkg::atan_turns(5'(i))});

    always_ff @(posedge clk) begin
      if (!z[i][33]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - atan_c;
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + atan_c;
      end
      quad[i+1] <= quad[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid[i+1] <= 1'b0;
      end else begin
        stage_valid[i+1] <= stage_valid[i];
      end
    end
  end

  // quadrant fold
  always_comb begin
    case (quad[NumStages])
      2'd0: begin
        c_pre = x[NumStages];
        s_pre = y[NumStages];
      end
      2'd1: begin
        c_pre = -y[NumStages];
        s_pre = x[NumStages];
      end
      2'd2: begin
        c_pre = -x[NumStages];
        s_pre = -y[NumStages];
      end
      default: begin
        c_pre = y[NumStages];
        s_pre = -x[NumStages];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cos_q30 <= aarm_pkg::sat_q30({{2{c_pre[33]}}, c_pre});
    sin_q30 <= aarm_pkg::sat_q30({{2{s_pre[33]}}, s_pre});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= stage_valid[NumStages];
    end
  end

endmodule

[rtl/aarm_axis.sv]
module aarm_axis (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] axis_x,
  input  logic signed [31:0] axis_y,
  input  logic signed [31:0] axis_z,
  output logic               out_valid,
  output logic signed [31:0] ux,
  output logic signed [31:0] uy,
  output logic signed [31:0] uz,
  output logic               zero
);

  localparam int Sq = aarm_pkg::SqrtSteps;
  localparam int Dv = aarm_pkg::DivSteps;

  logic signed [31:0] raw [0:2];
  logic        [31:0] mag_in [0:2];
  logic        [31:0] max_in;

  // magnitude stage
  logic [31:0] m1_mag [0:2];
  logic [31:0] m1_max;
  logic [2:0]  m1_neg;
  logic        m1_zero;
  logic        m1_valid;

  // shift search stage
  logic [4:0]  msb;
  logic [4:0]  k_next;
  logic [4:0]  k2_shift;
  logic [31:0] k2_mag [0:2];
  logic [2:0]  k2_neg;
  logic        k2_zero;
  logic        k2_valid;

  // normalized magnitudes
  logic [31:0] n3_mag [0:2];
  logic [2:0]  n3_neg;
  logic        n3_zero;
  logic        n3_valid;

  // squares
  logic [63:0] p4_sq [0:2];
  logic [31:0] p4_mag [0:2];
  logic [2:0]  p4_neg;
  logic        p4_zero;
  logic        p4_valid;

  // square root steps
  logic [63:0] sq_rem [0:Sq];
  logic [63:0] sq_res [0:Sq];
  logic [31:0] sq_mag [0:Sq][0:2];
  logic [2:0]  sq_neg [0:Sq];
  logic        sq_zero [0:Sq];
  logic        sq_valid [0:Sq];

  // quotient steps
  logic [63:0] dv_rem [0:Dv][0:2];
  logic [30:0] dv_quo [0:Dv][0:2];
  logic [31:0] dv_n [0:Dv];
  logic [2:0]  dv_neg [0:Dv];
  logic        dv_zero [0:Dv];
  logic        dv_valid [0:Dv];

  logic signed [31:0] u_next [0:2];

  assign raw[0] = axis_x;
  assign raw[1] = axis_y;
  assign raw[2] = axis_z;

  always_comb begin
    max_in = '0;
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = raw[k][31] ? (32'd0 - raw[k]) : raw[k];
      if (mag_in[k] > max_in) begin
        max_in = mag_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    m1_mag  <= mag_in;
    m1_max  <= max_in;
    m1_neg  <= {raw[2][31], raw[1][31], raw[0][31]};
    m1_zero <= (max_in == 32'd0);
  end

  // smallest shift that brings the largest magnitude to 2^30 or above
  always_comb begin
    msb = '0;
    for (int b = 0; b < 32; b++) begin
      if (m1_max[b]) begin
        msb = 5'(b);
      end
    end
    k_next = (msb >= 5'd30) ? 5'd0 : (5'd30 - msb);
  end

  always_ff @(posedge clk) begin
    k2_shift <= k_next;
    k2_mag   <= m1_mag;
    k2_neg   <= m1_neg;
    k2_zero  <= m1_zero;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      n3_mag[k] <= k2_mag[k] << k2_shift;
    end
    n3_neg  <= k2_neg;
    n3_zero <= k2_zero;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p4_sq[k] <= n3_mag[k] * n3_mag[k];
    end
    p4_mag  <= n3_mag;
    p4_neg  <= n3_neg;
    p4_zero <= n3_zero;
  end

  always_ff @(posedge clk) begin
    sq_rem[0]  <= p4_sq[0] + p4_sq[1] + p4_sq[2];
    sq_res[0]  <= '0;
    sq_mag[0]  <= p4_mag;
    sq_neg[0]  <= p4_neg;
    sq_zero[0] <= p4_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid    <= 1'b0;
      k2_valid    <= 1'b0;
      n3_valid    <= 1'b0;
      p4_valid    <= 1'b0;
      sq_valid[0] <= 1'b0;
    end else begin
      m1_valid    <= in_valid;
      k2_valid    <= m1_valid;
      n3_valid    <= k2_valid;
      p4_valid    <= n3_valid;
      sq_valid[0] <= p4_valid;
    end
  end

  // one result bit per step
  for (genvar j = 0; j < Sq; j++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = sq_res[j] + Bit;

    always_ff @(posedge clk) begin
      if (sq_rem[j] >= trial) begin
        sq_rem[j+1] <= sq_rem[j] - trial;
        sq_res[j+1] <= (sq_res[j] >> 1) + Bit;
      end else begin
        sq_rem[j+1] <= sq_rem[j];
        sq_res[j+1] <= sq_res[j] >> 1;
      end
      sq_mag[j+1]  <= sq_mag[j];
      sq_neg[j+1]  <= sq_neg[j];
      sq_zero[j+1] <= sq_zero[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[j+1] <= 1'b0;
      end else begin
        sq_valid[j+1] <= sq_valid[j];
      end
    end
  end

  // rounded numerator, mag * 2^30 + n / 2
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dv_rem[0][k] <= {2'b00, sq_mag[Sq][k], 30'd0} + {33'd0, sq_res[Sq][31:1]};
      dv_quo[0][k] <= '0;
    end
    dv_n[0]    <= sq_res[Sq][31:0];
    dv_neg[0]  <= sq_neg[Sq];
    dv_zero[0] <= sq_zero[Sq];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= sq_valid[Sq];
    end
  end

  // restoring division, one quotient bit per step, three lanes
  for (genvar j = 0; j < Dv; j++) begin : g_div
    localparam int B = Dv - 1 - j;
    logic [63:0] dsh;
    assign dsh = {32'd0, dv_n[j]} << B;

    for (genvar k = 0; k < 3; k++) begin : g_lane
      always_ff @(posedge clk) begin
        if (dv_rem[j][k] >= dsh) begin
          dv_rem[j+1][k] <= dv_rem[j][k] - dsh;
          dv_quo[j+1][k] <= dv_quo[j][k] | (31'd1 << B);
        end else begin
          dv_rem[j+1][k] <= dv_rem[j][k];
          dv_quo[j+1][k] <= dv_quo[j][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      dv_n[j+1]    <= dv_n[j];
      dv_neg[j+1]  <= dv_neg[j];
      dv_zero[j+1] <= dv_zero[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_zero[Dv]) begin
        u_next[k] = '0;
      end else if (dv_neg[Dv][k]) begin
        u_next[k] = -$signed({1'b0, dv_quo[Dv][k]});
      end else begin
        u_next[k] = $signed({1'b0, dv_quo[Dv][k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    ux   <= u_next[0];
    uy   <= u_next[1];
    uz   <= u_next[2];
    zero <= dv_zero[Dv];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_valid[Dv];
    end
  end

endmodule

[rtl/axis_angle_to_rotation_matrix.sv]
// channel   | ports                  | direction | transaction
// ----------+------------------------+-----------+-----------------------------------
// command   | start, busy, item      | in        | edge with start high and busy low
// result    | done, result           | out       | edge that ends the cycle done is high
//
// one command every cycle while busy is low; each command's result passes through
// the axis unit (70 stages, dominated by the 32 root steps and 31 quotient steps),
// then through 5 stages of products and sums
// the sine/cosine path is shorter and is delayed to line up with the axis path
// synchronous reset clears the valid bits only; busy is high during reset
// the result strobe is never held off, so nothing in the pipe ever waits
module axis_angle_to_rotation_matrix #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  aarm_pkg::in_t    item,
  output logic             done,
  output aarm_pkg::out_t   result
);

  localparam int NumStages    = aarm_pkg::cordic_count(CORDIC_STAGES);
  localparam int TrigLatency  = NumStages + 3;
  localparam int Pad          = aarm_pkg::AxisLatency - TrigLatency;
  localparam int TotalLatency = aarm_pkg::AxisLatency + 5;

  logic               accept;

  logic               sc_valid;
  logic signed [31:0] sc_cos;
  logic signed [31:0] sc_sin;
  logic               ax_valid;
  logic signed [31:0] ax_ux;
  logic signed [31:0] ax_uy;
  logic signed [31:0] ax_uz;
  logic               ax_zero;

  // alignment line for sine and cosine
  logic signed [31:0] dly_cos [0:Pad-1];
  logic signed [31:0] dly_sin [0:Pad-1];
  logic               dly_valid [0:Pad-1];

  // products stage 1: raw cp*u and s*u
  logic signed [32:0] cp;
  logic signed [65:0] p1_a;
  logic signed [65:0] p1_b;
  logic signed [65:0] p1_d;
  logic signed [65:0] p1_sx;
  logic signed [65:0] p1_sy;
  logic signed [65:0] p1_sz;
  logic signed [31:0] p1_u [0:2];
  logic signed [31:0] p1_c;
  logic               p1_zero;
  logic               p1_valid;

  // stage 2: rounded
  logic signed [35:0] p2_a;
  logic signed [35:0] p2_b;
  logic signed [35:0] p2_d;
  logic signed [35:0] p2_sx;
  logic signed [35:0] p2_sy;
  logic signed [35:0] p2_sz;
  logic signed [31:0] p2_u [0:2];
  logic signed [31:0] p2_c;
  logic               p2_zero;
  logic               p2_valid;

  // stage 3: raw second products
  logic signed [65:0] p3_xx;
  logic signed [65:0] p3_xy;
  logic signed [65:0] p3_xz;
  logic signed [65:0] p3_yy;
  logic signed [65:0] p3_yz;
  logic signed [65:0] p3_zz;
  logic signed [35:0] p3_sx;
  logic signed [35:0] p3_sy;
  logic signed [35:0] p3_sz;
  logic signed [31:0] p3_c;
  logic               p3_zero;
  logic               p3_valid;

  // stage 4: rounded second products
  logic signed [35:0] p4_xx;
  logic signed [35:0] p4_xy;
  logic signed [35:0] p4_xz;
  logic signed [35:0] p4_yy;
  logic signed [35:0] p4_yz;
  logic signed [35:0] p4_zz;
  logic signed [35:0] p4_sx;
  logic signed [35:0] p4_sy;
  logic signed [35:0] p4_sz;
  logic signed [35:0] p4_c;
  logic               p4_zero;
  logic               p4_valid;

  // Q2.30 product rounding, half up
  function automatic logic signed [35:0] rnd_q30(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = (p + 66'sd536870912) >>> 30;
    return t[35:0];
  endfunction

  assign busy   = rst;
  assign accept = start && !busy;

  aarm_sincos #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_sincos (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .angle    (item.angle),
    .deg      (item.angle_in_degrees),
    .out_valid(sc_valid),
    .cos_q30  (sc_cos),
    .sin_q30  (sc_sin)
  );

  aarm_axis u_axis (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .axis_x   (item.axis_x),
    .axis_y   (item.axis_y),
    .axis_z   (item.axis_z),
    .out_valid(ax_valid),
    .ux       (ax_ux),
    .uy       (ax_uy),
    .uz       (ax_uz),
    .zero     (ax_zero)
  );

  // delay cos/sin so they meet the unit axis of the same transaction
  always_ff @(posedge clk) begin
    dly_cos[0] <= sc_cos;
    dly_sin[0] <= sc_sin;
    for (int i = 1; i < Pad; i++) begin
      dly_cos[i] <= dly_cos[i-1];
      dly_sin[i] <= dly_sin[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Pad; i++) begin
        dly_valid[i] <= 1'b0;
      end
    end else begin
      dly_valid[0] <= sc_valid;
      for (int i = 1; i < Pad; i++) begin
        dly_valid[i] <= dly_valid[i-1];
      end
    end
  end

  // one minus cosine, range [0, 2.0]
  assign cp = 33'sd1073741824 - {dly_cos[Pad-1][31], dly_cos[Pad-1]};

  always_ff @(posedge clk) begin
    p1_a    <= cp * ax_ux;
    p1_b    <= cp * ax_uy;
    p1_d    <= cp * ax_uz;
    p1_sx   <= dly_sin[Pad-1] * ax_ux;
    p1_sy   <= dly_sin[Pad-1] * ax_uy;
    p1_sz   <= dly_sin[Pad-1] * ax_uz;
    p1_u[0] <= ax_ux;
    p1_u[1] <= ax_uy;
    p1_u[2] <= ax_uz;
    p1_c    <= dly_cos[Pad-1];
    p1_zero <= ax_zero;
  end

  always_ff @(posedge clk) begin
    p2_a    <= rnd_q30(p1_a);
    p2_b    <= rnd_q30(p1_b);
    p2_d    <= rnd_q30(p1_d);
    p2_sx   <= rnd_q30(p1_sx);
    p2_sy   <= rnd_q30(p1_sy);
    p2_sz   <= rnd_q30(p1_sz);
    p2_u    <= p1_u;
    p2_c    <= p1_c;
    p2_zero <= p1_zero;
  end

  always_ff @(posedge clk) begin
    p3_xx   <= p2_a * p2_u[0];
    p3_xy   <= p2_a * p2_u[1];
    p3_xz   <= p2_a * p2_u[2];
    p3_yy   <= p2_b * p2_u[1];
    p3_yz   <= p2_b * p2_u[2];
    p3_zz   <= p2_d * p2_u[2];
    p3_sx   <= p2_sx;
    p3_sy   <= p2_sy;
    p3_sz   <= p2_sz;
    p3_c    <= p2_c;
    p3_zero <= p2_zero;
  end

  always_ff @(posedge clk) begin
    p4_xx   <= rnd_q30(p3_xx);
    p4_xy   <= rnd_q30(p3_xy);
    p4_xz   <= rnd_q30(p3_xz);
    p4_yy   <= rnd_q30(p3_yy);
    p4_yz   <= rnd_q30(p3_yz);
    p4_zz   <= rnd_q30(p3_zz);
    p4_sx   <= p3_sx;
    p4_sy   <= p3_sy;
    p4_sz   <= p3_sz;
    p4_c    <= {{4{p3_c[31]}}, p3_c};
    p4_zero <= p3_zero;
  end

  // rodrigues terms in stored order, each clamped
  always_ff @(posedge clk) begin
    result.elem_0    <= aarm_pkg::sat_q30(p4_c + p4_xx);
    result.elem_1    <= aarm_pkg::sat_q30(p4_xy + p4_sz);
    result.elem_2    <= aarm_pkg::sat_q30(p4_xz - p4_sy);
    result.elem_3    <= aarm_pkg::sat_q30(p4_xy - p4_sz);
    result.elem_4    <= aarm_pkg::sat_q30(p4_c + p4_yy);
    result.elem_5    <= aarm_pkg::sat_q30(p4_yz + p4_sx);
    result.elem_6    <= aarm_pkg::sat_q30(p4_xz + p4_sy);
    result.elem_7    <= aarm_pkg::sat_q30(p4_yz - p4_sx);
    result.elem_8    <= aarm_pkg::sat_q30(p4_c + p4_zz);
    result.axis_zero <= p4_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      p1_valid <= ax_valid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      done     <= p4_valid;
    end
  end

  // both halves of a transaction must arrive together
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    dly_valid[Pad-1] == ax_valid)
    else $error("trig and axis paths out of step");

  // fixed latency from command to result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##TotalLatency done)
    else $error("result missing at expected cycle");

  // a zero axis leaves only a cosine-scaled identity
  a_zero_axis: assert property (@(posedge clk) disable iff (rst)
    done && result.axis_zero |->
      result.elem_1 == 32'sd0 && result.elem_2 == 32'sd0 && result.elem_3 == 32'sd0 &&
      result.elem_5 == 32'sd0 && result.elem_6 == 32'sd0 && result.elem_7 == 32'sd0 &&
      result.elem_0 == result.elem_4 && result.elem_4 == result.elem_8)
    else $error("zero axis gave a non-diagonal matrix");

endmodule
